// ----- hw/rtl/rttq_pkg.sv -----
`timescale 1ns / 1ps

package rttq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TIME_BITS_DEF   = 16;
    localparam int PRIO_BITS_DEF   = 8;

    localparam int ID_W     = 8;
    localparam int TIME_W   = 16;
    localparam int PRIO_W   = 8;
    localparam int STATUS_W = 2;

    localparam logic CMD_POST = 1'b0;
    localparam logic CMD_RUN  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_TAKEN = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd3;

    localparam logic [2:0] RES_FULL   = 3'd0;
    localparam logic [2:0] RES_TAKEN  = 3'd1;
    localparam logic [2:0] RES_EMPTY  = 3'd2;
    localparam logic [2:0] RES_POSTED = 3'd3;
    localparam logic [2:0] RES_RAN    = 3'd4;

    typedef logic [2:0] t_res;

    typedef struct packed {
        logic load;
        logic pop;
        logic scan;
        logic wr_new;
        logic wr_head;
        logic wr_best;
        logic finish;
        t_res res;
    } t_ctl;

    typedef struct packed {
        logic cmd_run;
        logic full;
        logic empty;
        logic scan_done;
        logic taken;
        logic have_best;
    } t_sts;

endpackage

// ----- hw/rtl/rttq_ctrl.sv -----
`timescale 1ns / 1ps

module rttq_ctrl import rttq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_sts i_sts,
    output t_ctl o_ctl
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_CHECK   = 3'd1;
    localparam logic [2:0] ST_SCAN    = 3'd2;
    localparam logic [2:0] ST_WR_HEAD = 3'd3;
    localparam logic [2:0] ST_WR_BEST = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    o_ctl.load = 1'b1;
                    n_state    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (!i_sts.cmd_run) begin
                    if (i_sts.full) begin
                        o_ctl.finish = 1'b1;
                        o_ctl.res    = RES_FULL;
                        n_state      = ST_IDLE;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end else begin
                    if (i_sts.empty) begin
                        o_ctl.finish = 1'b1;
                        o_ctl.res    = RES_EMPTY;
                        n_state      = ST_IDLE;
                    end else begin
                        o_ctl.pop = 1'b1;
                        n_state   = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                o_ctl.scan = 1'b1;
                if (i_sts.scan_done) begin
                    if (!i_sts.cmd_run) begin
                        o_ctl.finish = 1'b1;
                        n_state      = ST_IDLE;
                        if (i_sts.taken) begin
                            o_ctl.res = RES_TAKEN;
                        end else begin
                            o_ctl.wr_new = 1'b1;
                            o_ctl.res    = RES_POSTED;
                        end
                    end else if (i_sts.have_best) begin
                        n_state = ST_WR_HEAD;
                    end else begin
                        o_ctl.finish = 1'b1;
                        o_ctl.res    = RES_RAN;
                        n_state      = ST_IDLE;
                    end
                end
            end
            ST_WR_HEAD: begin
                o_ctl.wr_head = 1'b1;
                n_state       = ST_WR_BEST;
            end
            ST_WR_BEST: begin
                o_ctl.wr_best = 1'b1;
                o_ctl.finish  = 1'b1;
                o_ctl.res     = RES_RAN;
                n_state       = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy = !i_rst_n || (r_state != ST_IDLE);

endmodule

// ----- hw/rtl/rttq_dp.sv -----
`timescale 1ns / 1ps

module rttq_dp import rttq_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int TIME_BITS   = TIME_BITS_DEF,
    parameter int PRIO_BITS   = PRIO_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd,
    input  logic [ID_W-1:0]     i_task_id,
    input  logic [TIME_W-1:0]   i_due_time,
    input  logic [PRIO_W-1:0]   i_priority_req,
    input  t_ctl                i_ctl,
    output t_sts                o_sts,
    output logic [STATUS_W-1:0] o_status,
    output logic                o_ran_valid,
    output logic [ID_W-1:0]     o_ran_task,
    output logic                o_arm_valid,
    output logic [TIME_W-1:0]   o_arm_time,
    output logic                o_done
);

    localparam int IDX_W   = $clog2(QUEUE_DEPTH);
    localparam int ENTRY_W = ID_W + TIME_BITS + PRIO_BITS;
    localparam int T_LSB   = PRIO_BITS;
    localparam int ID_LSB  = PRIO_BITS + TIME_BITS;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

    function automatic logic [IDX_W-1:0] nxt(input logic [IDX_W-1:0] i);
        return (i == LAST_IDX) ? '0 : i + 1'b1;
    endfunction

    logic [ENTRY_W-1:0] r_mem [QUEUE_DEPTH];

    logic [IDX_W-1:0]     r_head;
    logic [IDX_W-1:0]     r_tail;
    logic                 r_cmd;
    logic [ID_W-1:0]      r_id;
    logic [TIME_BITS-1:0] r_time;
    logic [PRIO_BITS-1:0] r_prio;
    logic [IDX_W-1:0]     r_ptr;
    logic                 r_dv;
    logic [IDX_W-1:0]     r_didx;
    logic [ENTRY_W-1:0]   r_rd_data;
    logic                 r_skip;
    logic                 r_taken;
    logic                 r_have_best;
    logic [IDX_W-1:0]     r_best_idx;
    logic [ENTRY_W-1:0]   r_best_data;
    logic [ENTRY_W-1:0]   r_hd_data;
    logic [ID_W-1:0]      r_ran_task;

    logic [STATUS_W-1:0] r_status;
    logic                r_ran_valid;
    logic [ID_W-1:0]     r_ran_out;
    logic                r_arm_valid;
    logic [TIME_W-1:0]   r_arm_time;
    logic                r_done;

    logic [STATUS_W-1:0] n_status;
    logic                n_ran_valid;
    logic [ID_W-1:0]     n_ran_out;
    logic                n_arm_valid;
    logic [TIME_W-1:0]   n_arm_time;

    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    logic [ENTRY_W-1:0]   wr_data;
    logic                 rd_issue;
    logic [TIME_BITS-1:0] rd_time;
    logic [PRIO_BITS-1:0] rd_prio;
    logic [TIME_BITS-1:0] best_time;
    logic [PRIO_BITS-1:0] best_prio;
    logic [TIME_BITS-1:0] diff;
    logic                 better;

    assign rd_time   = r_rd_data[T_LSB +: TIME_BITS];
    assign rd_prio   = r_rd_data[PRIO_BITS-1:0];
    assign best_time = r_best_data[T_LSB +: TIME_BITS];
    assign best_prio = r_best_data[PRIO_BITS-1:0];
    assign diff      = rd_time - best_time;
    assign better    = (rd_prio >= best_prio) && diff[TIME_BITS-1];
    assign rd_issue  = i_ctl.scan && (r_ptr != r_tail);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_tail;
        wr_data = {r_id, r_time, r_prio};
        if (i_ctl.wr_new) begin
            wr_en = 1'b1;
        end else if (i_ctl.wr_head) begin
            wr_en   = 1'b1;
            wr_addr = r_head;
            wr_data = r_best_data;
        end else if (i_ctl.wr_best) begin
            wr_en   = 1'b1;
            wr_addr = r_best_idx;
            wr_data = r_hd_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_issue) begin
            r_rd_data <= r_mem[r_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_dv   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= i_ctl.finish;
            if (i_ctl.load) begin
                r_dv <= 1'b0;
            end else if (i_ctl.scan) begin
                r_dv <= rd_issue;
            end
            if (i_ctl.pop) begin
                r_head <= nxt(r_head);
            end
            if (i_ctl.wr_new) begin
                r_tail <= nxt(r_tail);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd       <= i_cmd;
            r_id        <= i_task_id;
            r_time      <= TIME_BITS'(i_due_time);
            r_prio      <= PRIO_BITS'(i_priority_req);
            r_ptr       <= r_head;
            r_skip      <= i_cmd;
            r_taken     <= 1'b0;
            r_have_best <= 1'b0;
        end else begin
            if (rd_issue) begin
                r_ptr  <= nxt(r_ptr);
                r_didx <= r_ptr;
            end
            if (i_ctl.scan && r_dv) begin
                if (r_cmd == CMD_POST) begin
                    if (rd_time == r_time) begin
                        r_taken <= 1'b1;
                    end
                end else if (r_skip) begin
                    r_ran_task <= r_rd_data[ID_LSB +: ID_W];
                    r_skip     <= 1'b0;
                end else if (!r_have_best) begin
                    r_have_best <= 1'b1;
                    r_best_data <= r_rd_data;
                    r_best_idx  <= r_didx;
                    r_hd_data   <= r_rd_data;
                end else if (better) begin
                    r_best_data <= r_rd_data;
                    r_best_idx  <= r_didx;
                end
            end
        end
    end

    always_comb begin
        n_status    = STATUS_OK;
        n_ran_valid = 1'b0;
        n_ran_out   = '0;
        n_arm_valid = 1'b0;
        n_arm_time  = '0;
        case (i_ctl.res)
            RES_FULL: begin
                n_status = STATUS_FULL;
            end
            RES_TAKEN: begin
                n_status = STATUS_TAKEN;
            end
            RES_EMPTY: begin
                n_status = STATUS_EMPTY;
            end
            RES_POSTED: begin
                if (r_head == r_tail) begin
                    n_arm_valid = 1'b1;
                    n_arm_time  = TIME_W'(r_time);
                end
            end
            RES_RAN: begin
                n_ran_valid = 1'b1;
                n_ran_out   = r_ran_task;
                if (r_have_best) begin
                    n_arm_valid = 1'b1;
                    n_arm_time  = TIME_W'(best_time);
                end
            end
            default: begin
                n_status = STATUS_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.finish) begin
            r_status    <= n_status;
            r_ran_valid <= n_ran_valid;
            r_ran_out   <= n_ran_out;
            r_arm_valid <= n_arm_valid;
            r_arm_time  <= n_arm_time;
        end
    end

    assign o_sts.cmd_run   = (r_cmd == CMD_RUN);
    assign o_sts.full      = (nxt(r_tail) == r_head);
    assign o_sts.empty     = (r_head == r_tail);
    assign o_sts.scan_done = (r_ptr == r_tail) && !r_dv;
    assign o_sts.taken     = r_taken;
    assign o_sts.have_best = r_have_best;

    assign o_status    = r_status;
    assign o_ran_valid = r_ran_valid;
    assign o_ran_task  = r_ran_out;
    assign o_arm_valid = r_arm_valid;
    assign o_arm_time  = r_arm_time;
    assign o_done      = r_done;

endmodule

// ----- hw/rtl/realtime_task_timer_queue_unit.sv -----
`timescale 1ns / 1ps

// Timer queue of posted tasks, run earliest first within priority. A word is
// taken when start is high and busy is low; busy is held high during reset. Its
// result appears on the o_ ports with o_done high for one cycle, and the
// receiver cannot stall it. Task slots sit in one memory with a single read
// port, so each command walks the queued entries one per cycle. A run that
// leaves tasks behind then swaps the chosen task into the head slot, writing
// the head slot and then the chosen slot. A post refused as full or a run on
// an empty queue answers from the check state without walking the queue. The
// queue holds QUEUE_DEPTH - 1 tasks.
module realtime_task_timer_queue_unit import rttq_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int TIME_BITS   = TIME_BITS_DEF,
    parameter int PRIO_BITS   = PRIO_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_cmd,
    input  logic [ID_W-1:0]     i_task_id,
    input  logic [TIME_W-1:0]   i_due_time,
    input  logic [PRIO_W-1:0]   i_priority_req,
    output logic [STATUS_W-1:0] o_status,
    output logic                o_ran_valid,
    output logic [ID_W-1:0]     o_ran_task,
    output logic                o_arm_valid,
    output logic [TIME_W-1:0]   o_arm_time,
    output logic                o_done
);

    t_ctl ctl;
    t_sts sts;

    rttq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_ctl   (ctl)
    );

    rttq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TIME_BITS   (TIME_BITS),
        .PRIO_BITS   (PRIO_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (i_cmd),
        .i_task_id      (i_task_id),
        .i_due_time     (i_due_time),
        .i_priority_req (i_priority_req),
        .i_ctl          (ctl),
        .o_sts          (sts),
        .o_status       (o_status),
        .o_ran_valid    (o_ran_valid),
        .o_ran_task     (o_ran_task),
        .o_arm_valid    (o_arm_valid),
        .o_arm_time     (o_arm_time),
        .o_done         (o_done)
    );

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import rttq_pkg::*;

    localparam int DEPTH        = QUEUE_DEPTH_DEF;
    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 25;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                ran_valid;
        logic [ID_W-1:0]     ran_task;
        logic                arm_valid;
        logic [TIME_W-1:0]   arm_time;
    } t_outcome;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic                i_cmd;
    logic [ID_W-1:0]     i_task_id;
    logic [TIME_W-1:0]   i_due_time;
    logic [PRIO_W-1:0]   i_priority_req;
    logic [STATUS_W-1:0] o_status;
    logic                o_ran_valid;
    logic [ID_W-1:0]     o_ran_task;
    logic                o_arm_valid;
    logic [TIME_W-1:0]   o_arm_time;
    logic                o_done;

    logic [ID_W-1:0]   slot_id   [DEPTH];
    logic [TIME_W-1:0] slot_time [DEPTH];
    logic [PRIO_W-1:0] slot_prio [DEPTH];
    int head_ptr = 0;
    int tail_ptr = 0;

    t_outcome pending_results[$];
    int mismatch_count = 0;
    int idle_cycles = 0;
    int burst_left = 0;

    realtime_task_timer_queue_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .i_task_id      (i_task_id),
        .i_due_time     (i_due_time),
        .i_priority_req (i_priority_req),
        .o_status       (o_status),
        .o_ran_valid    (o_ran_valid),
        .o_ran_task     (o_ran_task),
        .o_arm_valid    (o_arm_valid),
        .o_arm_time     (o_arm_time),
        .o_done         (o_done)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int queued_count();
        return (tail_ptr - head_ptr + DEPTH) % DEPTH;
    endfunction

    function automatic bit time_before(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b);
        logic [TIME_W-1:0] diff;
        diff = a - b;
        return diff[TIME_W-1];
    endfunction

    function automatic t_outcome schedule_step(input logic cmd, input logic [ID_W-1:0] id,
                                               input logic [TIME_W-1:0] t,
                                               input logic [PRIO_W-1:0] p);
        t_outcome res;
        int i;
        int best;
        bit taken;
        logic [ID_W-1:0] sid;
        logic [TIME_W-1:0] st;
        logic [PRIO_W-1:0] sp;
        res = '0;
        res.status = STATUS_OK;
        if (cmd == CMD_POST) begin
            if ((tail_ptr + 1) % DEPTH == head_ptr) begin
                res.status = STATUS_FULL;
            end else begin
                taken = 1'b0;
                for (i = head_ptr; i != tail_ptr; i = (i + 1) % DEPTH) begin
                    if (slot_time[i] == t) taken = 1'b1;
                end
                if (taken) begin
                    res.status = STATUS_TAKEN;
                end else begin
                    slot_id[tail_ptr] = id;
                    slot_time[tail_ptr] = t;
                    slot_prio[tail_ptr] = p;
                    tail_ptr = (tail_ptr + 1) % DEPTH;
                    if (tail_ptr == (head_ptr + 1) % DEPTH) begin
                        res.arm_valid = 1'b1;
                        res.arm_time = t;
                    end
                end
            end
        end else if (head_ptr == tail_ptr) begin
            res.status = STATUS_EMPTY;
        end else begin
            res.ran_valid = 1'b1;
            res.ran_task = slot_id[head_ptr];
            head_ptr = (head_ptr + 1) % DEPTH;
            if (head_ptr != tail_ptr) begin
                best = head_ptr;
                for (i = head_ptr; i != tail_ptr; i = (i + 1) % DEPTH) begin
                    if (slot_prio[i] >= slot_prio[best] &&
                        time_before(slot_time[i], slot_time[best])) best = i;
                end
                sid = slot_id[head_ptr];
                st = slot_time[head_ptr];
                sp = slot_prio[head_ptr];
                slot_id[head_ptr] = slot_id[best];
                slot_time[head_ptr] = slot_time[best];
                slot_prio[head_ptr] = slot_prio[best];
                slot_id[best] = sid;
                slot_time[best] = st;
                slot_prio[best] = sp;
                res.arm_valid = 1'b1;
                res.arm_time = slot_time[head_ptr];
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        mismatch_count++;
        $display("ERROR %0t: %s expected %0h got %0h", $realtime, what, want, got);
    endtask

    task automatic send_word(input logic cmd, input logic [ID_W-1:0] id,
                             input logic [TIME_W-1:0] t, input logic [PRIO_W-1:0] p);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 25) : $urandom_range(0, 3);
            repeat (gap) begin
                @(negedge i_clk);
                start <= 1'b0;
            end
            burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge i_clk);
        start <= 1'b1;
        i_cmd <= cmd;
        i_task_id <= id;
        i_due_time <= t;
        i_priority_req <= p;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_results.push_back(schedule_step(cmd, id, t, p));
    endtask

    task automatic test_empty_run();
        send_word(CMD_RUN, ID_W'($urandom), TIME_W'($urandom), PRIO_W'($urandom));
    endtask

    task automatic test_post_and_run();
        send_word(CMD_POST, '0, '0, '0);
        send_word(CMD_POST, '1, '1, '1);
        send_word(CMD_POST, ID_W'(7), '0, PRIO_W'(9));
        send_word(CMD_RUN, '0, '0, '0);
        send_word(CMD_RUN, '1, '1, '1);
        send_word(CMD_RUN, '0, '0, '0);
    endtask

    task automatic test_wrap_order();
        send_word(CMD_POST, ID_W'(1), TIME_W'(16'hFFF0), PRIO_W'(5));
        send_word(CMD_POST, ID_W'(2), TIME_W'(16'h0008), PRIO_W'(5));
        send_word(CMD_POST, ID_W'(3), TIME_W'(16'hFFE0), PRIO_W'(4));
        send_word(CMD_POST, ID_W'(4), TIME_W'(16'hFFE8), PRIO_W'(200));
        send_word(CMD_RUN, '0, '0, '0);
    endtask

    task automatic test_full_queue();
        int k;
        for (k = 1; k <= 12; k++) begin
            send_word(CMD_POST, ID_W'(k + 16), TIME_W'(k * 16'h1111),
                      (k % 3 == 0) ? '1 : PRIO_W'(k));
        end
        send_word(CMD_POST, ID_W'(99), TIME_W'(16'h7F7F), PRIO_W'(1));
        send_word(CMD_POST, ID_W'(98), TIME_W'(16'h1111), PRIO_W'(1));
    endtask

    task automatic test_random_traffic(input int n_words);
        int n;
        int seg_left;
        int run_pct;
        int pick;
        int cnt;
        logic cmd;
        logic [ID_W-1:0] id;
        logic [TIME_W-1:0] t;
        logic [TIME_W-1:0] base;
        logic [PRIO_W-1:0] p;
        seg_left = 0;
        run_pct = 50;
        base = '0;
        for (n = 0; n < n_words; n++) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(40, 160);
                case ($urandom_range(0, 2))
                    0: run_pct = 20;
                    1: run_pct = 75;
                    default: run_pct = 50;
                endcase
                base = ($urandom_range(0, 3) == 0) ? TIME_W'(16'hFFE0) : TIME_W'($urandom);
            end
            seg_left--;
            cmd = ($urandom_range(0, 99) < run_pct) ? CMD_RUN : CMD_POST;
            cnt = queued_count();
            pick = $urandom_range(0, 9);
            if (pick < 3 && cnt > 0)
                t = slot_time[(head_ptr + int'($urandom_range(0, cnt - 1))) % DEPTH];
            else if (pick < 6)
                t = TIME_W'($urandom);
            else
                t = base + TIME_W'($urandom_range(0, 63));
            case ($urandom_range(0, 5))
                0: p = '0;
                1: p = '1;
                2: p = PRIO_W'(50);
                default: p = PRIO_W'($urandom);
            endcase
            id = ID_W'($urandom);
            send_word(cmd, id, t, p);
        end
    endtask

    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no word pending", '0, '0);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", 32'(want.status), 32'(o_status));
                if (o_ran_valid !== want.ran_valid)
                    report_mismatch("ran_valid", 32'(want.ran_valid), 32'(o_ran_valid));
                if (o_ran_task !== want.ran_task)
                    report_mismatch("ran_task", 32'(want.ran_task), 32'(o_ran_task));
                if (o_arm_valid !== want.arm_valid)
                    report_mismatch("arm_valid", 32'(want.arm_valid), 32'(o_arm_valid));
                if (o_arm_time !== want.arm_time)
                    report_mismatch("arm_time", 32'(want.arm_time), 32'(o_arm_time));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) begin
            idle_cycles = 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles++;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cmd = CMD_POST;
        i_task_id = '0;
        i_due_time = '0;
        i_priority_req = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_run();
        test_post_and_run();
        test_wrap_order();
        test_full_queue();
        test_random_traffic(1700);
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
